// ----- design/adaptive_huffman_encoder_core_macros.svh -----
// Assertion macros for the adaptive Huffman encoder core.
// Included by the modules that carry concurrent assertions.
`ifndef ADAPTIVE_HUFFMAN_ENCODER_CORE_MACROS_SVH
`define ADAPTIVE_HUFFMAN_ENCODER_CORE_MACROS_SVH
`ifndef SYNTH
`define AHE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define AHE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AHE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define AHE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- design/ahe_pkg.sv -----
// Shared constants, payload types and controller/datapath interface types
// for the adaptive Huffman encoder core. No dependencies.
package ahe_pkg;

    localparam int ALPHABET    = 256;
    localparam int WEIGHT_BITS = 32;
    localparam int NODES       = 2 * ALPHABET + 1;
    localparam int IDX_W       = $clog2(NODES);
    localparam int SYM_W       = 8;
    localparam int BYTE_W      = 8;
    localparam int DEPTH_W     = $clog2(ALPHABET + 1);
    localparam int STK_W       = $clog2(ALPHABET);
    localparam int FILL_W      = 3;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = '1;

    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [SYM_W-1:0] symbol_byte;
    } ahe_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
        logic              weight_overflow;
    } ahe_out_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_START,
        OP_PATH_LEAF,
        OP_PATH_ESC,
        OP_RD_X,
        OP_RD_P,
        OP_PUSH,
        OP_POP_RD,
        OP_PUT_STACK,
        OP_PUT_RAW,
        OP_RD_E,
        OP_SPLIT_A,
        OP_SPLIT_B,
        OP_U_LEAF,
        OP_RD_U,
        OP_U_CAP,
        OP_RD_I,
        OP_CMP,
        OP_RD_PA,
        OP_CAP_A,
        OP_RD_PB,
        OP_CAP_B,
        OP_SW_A,
        OP_SW_B,
        OP_INC,
        OP_PAD,
        OP_FINISH
    } ahe_op_t;

    typedef struct packed {
        ahe_op_t op;
    } ahe_cmd_t;

    typedef struct packed {
        logic is_flush;
        logic sym_out_range;
        logic leaf_valid;
        logic any_seen;
        logic ovf;
        logic walk_more;
        logic depth_nz;
        logic can_push;
        logic raw_last;
        logic scan_last;
        logic do_swap;
        logic u_is_root;
    } ahe_status_t;

endpackage

// ----- design/adaptive_huffman_encoder_core.sv -----
// Top level of the adaptive Huffman (FGK) byte encoder core.
// Depends on ahe_pkg, ahe_ctrl and ahe_dp.
//
// channel  signals                            payload
// -------  ---------------------------------  ---------------------------------
// sym      sym_valid / sym_ready / sym_req    cmd, symbol_byte
// code     code_valid / code_ready / code     out_byte, last_of_run, weight_overflow
//
// One request at a time; sym_ready is high only between requests.
// Path coding walks the tree level by level and emits each code bit from the stack, then any raw bits;
// the weight update visits every tree level on the path and scans all live nodes once per level
// through the single node-table read port, with extra steps on a swap.
// Reset is immediate: node tables need no clearing pass, the symbol map uses valid bits.
// A stalled code channel holds the core at its next emitted bit once a completed byte waits in the hold register.
module adaptive_huffman_encoder_core import ahe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     sym_valid,
    output logic     sym_ready,
    input  ahe_in_t  sym_req,
    output logic     code_valid,
    input  logic     code_ready,
    output ahe_out_t code
);

    ahe_cmd_t    cmd;
    ahe_status_t status;

    ahe_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (sym_valid),
        .req_ready (sym_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ahe_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (sym_req),
        .cmd       (cmd),
        .status    (status),
        .out_valid (code_valid),
        .out_ready (code_ready),
        .out_data  (code)
    );

endmodule

// ----- design/ahe_ctrl.sv -----
// Controller state machine for the adaptive Huffman encoder core.
// Depends on ahe_pkg; drives datapath commands from datapath status.
module ahe_ctrl import ahe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  ahe_status_t status,
    output ahe_cmd_t    cmd
);

    typedef enum logic [26:0] {
        S_IDLE   = 27'd1 << 0,
        S_DECIDE = 27'd1 << 1,
        S_WCHK   = 27'd1 << 2,
        S_WRDX   = 27'd1 << 3,
        S_WRDP   = 27'd1 << 4,
        S_WPUSH  = 27'd1 << 5,
        S_PRD    = 27'd1 << 6,
        S_PPUT   = 27'd1 << 7,
        S_POST   = 27'd1 << 8,
        S_SRD    = 27'd1 << 9,
        S_SA     = 27'd1 << 10,
        S_SB     = 27'd1 << 11,
        S_RAW    = 27'd1 << 12,
        S_URD    = 27'd1 << 13,
        S_UCAP   = 27'd1 << 14,
        S_IRD    = 27'd1 << 15,
        S_ICMP   = 27'd1 << 16,
        S_SDEC   = 27'd1 << 17,
        S_ARD    = 27'd1 << 18,
        S_ACAP   = 27'd1 << 19,
        S_BRD    = 27'd1 << 20,
        S_BCAP   = 27'd1 << 21,
        S_WA     = 27'd1 << 22,
        S_WB     = 27'd1 << 23,
        S_INC    = 27'd1 << 24,
        S_PAD    = 27'd1 << 25,
        S_FIN    = 27'd1 << 26
    } ahe_state_t;

    ahe_state_t state_reg;
    ahe_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        req_ready  = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op     = OP_START;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (status.is_flush)
                begin
                    cmd.op     = OP_PATH_ESC;
                    state_next = S_WCHK;
                end
                else if (status.sym_out_range)
                begin
                    state_next = S_IDLE;
                end
                else if (status.leaf_valid)
                begin
                    cmd.op     = OP_PATH_LEAF;
                    state_next = S_WCHK;
                end
                else if (status.any_seen)
                begin
                    cmd.op     = OP_PATH_ESC;
                    state_next = S_WCHK;
                end
                else
                begin
                    state_next = S_SRD;
                end
            end
            S_WCHK:
            begin
                if (status.walk_more)
                    state_next = S_WRDX;
                else if (status.depth_nz)
                    state_next = S_PRD;
                else
                    state_next = S_POST;
            end
            S_WRDX:
            begin
                cmd.op     = OP_RD_X;
                state_next = S_WRDP;
            end
            S_WRDP:
            begin
                cmd.op     = OP_RD_P;
                state_next = S_WPUSH;
            end
            S_WPUSH:
            begin
                cmd.op     = OP_PUSH;
                state_next = S_WCHK;
            end
            S_PRD:
            begin
                cmd.op     = OP_POP_RD;
                state_next = S_PPUT;
            end
            S_PPUT:
            begin
                if (status.can_push)
                begin
                    cmd.op     = OP_PUT_STACK;
                    state_next = status.depth_nz ? S_PRD : S_POST;
                end
            end
            S_POST:
            begin
                if (status.is_flush)
                    state_next = S_PAD;
                else if (!status.leaf_valid)
                    state_next = S_SRD;
                else if (status.ovf)
                    state_next = S_FIN;
                else
                begin
                    cmd.op     = OP_U_LEAF;
                    state_next = S_URD;
                end
            end
            S_SRD:
            begin
                cmd.op     = OP_RD_E;
                state_next = S_SA;
            end
            S_SA:
            begin
                cmd.op     = OP_SPLIT_A;
                state_next = S_SB;
            end
            S_SB:
            begin
                cmd.op     = OP_SPLIT_B;
                state_next = S_RAW;
            end
            S_RAW:
            begin
                if (status.can_push)
                begin
                    cmd.op = OP_PUT_RAW;
                    if (status.raw_last)
                        state_next = status.ovf ? S_FIN : S_URD;
                end
            end
            S_URD:
            begin
                cmd.op     = OP_RD_U;
                state_next = S_UCAP;
            end
            S_UCAP:
            begin
                cmd.op     = OP_U_CAP;
                state_next = S_IRD;
            end
            S_IRD:
            begin
                cmd.op     = OP_RD_I;
                state_next = S_ICMP;
            end
            S_ICMP:
            begin
                cmd.op     = OP_CMP;
                state_next = status.scan_last ? S_SDEC : S_IRD;
            end
            S_SDEC:
            begin
                state_next = status.do_swap ? S_ARD : S_INC;
            end
            S_ARD:
            begin
                cmd.op     = OP_RD_PA;
                state_next = S_ACAP;
            end
            S_ACAP:
            begin
                cmd.op     = OP_CAP_A;
                state_next = S_BRD;
            end
            S_BRD:
            begin
                cmd.op     = OP_RD_PB;
                state_next = S_BCAP;
            end
            S_BCAP:
            begin
                cmd.op     = OP_CAP_B;
                state_next = S_WA;
            end
            S_WA:
            begin
                cmd.op     = OP_SW_A;
                state_next = S_WB;
            end
            S_WB:
            begin
                cmd.op     = OP_SW_B;
                state_next = S_INC;
            end
            S_INC:
            begin
                cmd.op     = OP_INC;
                state_next = status.u_is_root ? S_FIN : S_URD;
            end
            S_PAD:
            begin
                if (status.can_push)
                begin
                    cmd.op     = OP_PAD;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (status.can_push)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- design/ahe_dp.sv -----
// Datapath of the adaptive Huffman encoder core: node tables, symbol map,
// path stack, bit packer and output register. Depends on ahe_pkg and the macros header.
`include "adaptive_huffman_encoder_core_macros.svh"
module ahe_dp import ahe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ahe_in_t     req,
    input  ahe_cmd_t    cmd,
    output ahe_status_t status,
    output logic        out_valid,
    input  logic        out_ready,
    output ahe_out_t    out_data
);

    logic [IDX_W-1:0]       par_mem   [NODES];
    logic [IDX_W-1:0]       right_mem [NODES];
    logic [WEIGHT_BITS-1:0] w_mem     [NODES];
    logic [IDX_W-1:0]       ord_mem   [NODES];
    logic [IDX_W-1:0]       leaf_mem  [ALPHABET];
    logic                   stk_mem   [ALPHABET];

    logic [IDX_W-1:0]       nu_reg, nu_next;
    logic [IDX_W-1:0]       esc_reg, esc_next;
    logic                   any_seen_reg, any_seen_next;
    logic [BYTE_W-1:0]      pend_bits_reg, pend_bits_next;
    logic [FILL_W-1:0]      pend_fill_reg, pend_fill_next;
    logic [WEIGHT_BITS-1:0] root_w_reg, root_w_next;
    logic [ALPHABET-1:0]    leaf_vld_reg, leaf_vld_next;
    logic                   hold_v_reg, hold_v_next;
    logic                   out_valid_reg, out_valid_next;

    logic                   cmd_flag_reg, cmd_flag_next;
    logic [SYM_W-1:0]       sym_reg, sym_next;
    logic                   ovf_reg, ovf_next;
    logic [IDX_W-1:0]       x_reg, x_next;
    logic [IDX_W-1:0]       p_reg, p_next;
    logic [DEPTH_W-1:0]     depth_reg, depth_next;
    logic [2:0]             raw_cnt_reg, raw_cnt_next;
    logic [IDX_W-1:0]       u_reg, u_next;
    logic [WEIGHT_BITS-1:0] u_w_reg, u_w_next;
    logic [IDX_W-1:0]       u_ord_reg, u_ord_next;
    logic [IDX_W-1:0]       u_par_reg, u_par_next;
    logic [IDX_W-1:0]       lead_reg, lead_next;
    logic [IDX_W-1:0]       lead_ord_reg, lead_ord_next;
    logic [IDX_W-1:0]       lead_par_reg, lead_par_next;
    logic [IDX_W-1:0]       i_reg, i_next;
    logic                   a_right_reg, a_right_next;
    logic                   b_right_reg, b_right_next;
    logic [BYTE_W-1:0]      hold_byte_reg, hold_byte_next;
    ahe_out_t               out_data_reg, out_data_next;

    logic [IDX_W-1:0]       rd_addr_reg;
    logic [IDX_W-1:0]       rd_par_reg;
    logic [IDX_W-1:0]       rd_right_reg;
    logic [WEIGHT_BITS-1:0] rd_w_raw_reg;
    logic [IDX_W-1:0]       rd_ord_raw_reg;
    logic [IDX_W-1:0]       leaf_idx_reg;
    logic                   stk_bit_reg;

    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   par_we, right_we, w_we, ord_we, leaf_we, leaf_re;
    logic                   stk_we, stk_re;
    logic [IDX_W-1:0]       par_wa, par_wd, right_wa, right_wd, ord_wa, ord_wd;
    logic [IDX_W-1:0]       w_wa, leaf_wd;
    logic [WEIGHT_BITS-1:0] w_wd;
    logic [STK_W-1:0]       leaf_wa, leaf_ra, stk_wa, stk_ra;
    logic                   stk_wd;

    logic [WEIGHT_BITS-1:0] rd_w;
    logic [IDX_W-1:0]       rd_ord;
    logic                   out_free;
    logic                   bit_put, bit_val, push, move, move_last;
    logic [BYTE_W-1:0]      push_byte, move_byte, bits_w;
    logic [DEPTH_W-1:0]     depth_dec;
    logic [IDX_W-1:0]       nu_inc;

    assign rd_w      = (rd_addr_reg == '0) ? root_w_reg : rd_w_raw_reg;
    assign rd_ord    = (rd_addr_reg == '0) ? '0 : rd_ord_raw_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign depth_dec = depth_reg - DEPTH_W'(1);
    assign nu_inc    = nu_reg + IDX_W'(1);

    always_comb
    begin
        nu_next        = nu_reg;
        esc_next       = esc_reg;
        any_seen_next  = any_seen_reg;
        pend_bits_next = pend_bits_reg;
        pend_fill_next = pend_fill_reg;
        root_w_next    = root_w_reg;
        leaf_vld_next  = leaf_vld_reg;
        hold_v_next    = hold_v_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd_flag_next  = cmd_flag_reg;
        sym_next       = sym_reg;
        ovf_next       = ovf_reg;
        x_next         = x_reg;
        p_next         = p_reg;
        depth_next     = depth_reg;
        raw_cnt_next   = raw_cnt_reg;
        u_next         = u_reg;
        u_w_next       = u_w_reg;
        u_ord_next     = u_ord_reg;
        u_par_next     = u_par_reg;
        lead_next      = lead_reg;
        lead_ord_next  = lead_ord_reg;
        lead_par_next  = lead_par_reg;
        i_next         = i_reg;
        a_right_next   = a_right_reg;
        b_right_next   = b_right_reg;
        hold_byte_next = hold_byte_reg;
        out_data_next  = out_data_reg;

        rd_en    = 1'b0;
        rd_addr  = '0;
        par_we   = 1'b0;
        par_wa   = '0;
        par_wd   = '0;
        right_we = 1'b0;
        right_wa = '0;
        right_wd = '0;
        w_we     = 1'b0;
        w_wa     = '0;
        w_wd     = '0;
        ord_we   = 1'b0;
        ord_wa   = '0;
        ord_wd   = '0;
        leaf_we  = 1'b0;
        leaf_wa  = '0;
        leaf_wd  = '0;
        leaf_re  = 1'b0;
        leaf_ra  = '0;
        stk_we   = 1'b0;
        stk_wa   = '0;
        stk_wd   = 1'b0;
        stk_re   = 1'b0;
        stk_ra   = '0;
        bit_put  = 1'b0;
        bit_val  = 1'b0;
        push     = 1'b0;
        push_byte = '0;
        move      = 1'b0;
        move_last = 1'b0;
        move_byte = hold_byte_reg;
        bits_w    = '0;

        case (cmd.op)
            OP_START:
            begin
                cmd_flag_next = req.cmd;
                sym_next      = req.symbol_byte;
                ovf_next      = (req.cmd == CMD_DATA) && (root_w_reg == WEIGHT_MAX);
                leaf_re       = 1'b1;
                leaf_ra       = req.symbol_byte[STK_W-1:0];
            end
            OP_PATH_LEAF:
            begin
                x_next     = leaf_idx_reg;
                depth_next = '0;
            end
            OP_PATH_ESC:
            begin
                x_next     = esc_reg;
                depth_next = '0;
            end
            OP_RD_X:
            begin
                rd_en   = 1'b1;
                rd_addr = x_reg;
            end
            OP_RD_P:
            begin
                rd_en   = 1'b1;
                rd_addr = rd_par_reg;
                p_next  = rd_par_reg;
            end
            OP_PUSH:
            begin
                stk_we     = 1'b1;
                stk_wa     = depth_reg[STK_W-1:0];
                stk_wd     = (rd_right_reg == x_reg);
                x_next     = p_reg;
                depth_next = depth_reg + DEPTH_W'(1);
            end
            OP_POP_RD:
            begin
                depth_next = depth_dec;
                stk_re     = 1'b1;
                stk_ra     = depth_dec[STK_W-1:0];
            end
            OP_PUT_STACK:
            begin
                bit_put = 1'b1;
                bit_val = stk_bit_reg;
            end
            OP_PUT_RAW:
            begin
                bit_put      = 1'b1;
                bit_val      = sym_reg[raw_cnt_reg];
                raw_cnt_next = raw_cnt_reg + 3'd1;
            end
            OP_RD_E:
            begin
                rd_en   = 1'b1;
                rd_addr = esc_reg;
            end
            OP_SPLIT_A:
            begin
                par_we   = 1'b1;
                par_wa   = nu_reg;
                par_wd   = esc_reg;
                w_we     = 1'b1;
                w_wa     = nu_reg;
                w_wd     = '0;
                ord_we   = 1'b1;
                ord_wa   = nu_reg;
                ord_wd   = rd_ord + IDX_W'(1);
                right_we = 1'b1;
                right_wa = esc_reg;
                right_wd = nu_reg;
            end
            OP_SPLIT_B:
            begin
                par_we        = 1'b1;
                par_wa        = nu_inc;
                par_wd        = esc_reg;
                w_we          = 1'b1;
                w_wa          = nu_inc;
                w_wd          = '0;
                ord_we        = 1'b1;
                ord_wa        = nu_inc;
                ord_wd        = rd_ord + IDX_W'(2);
                leaf_we       = 1'b1;
                leaf_wa       = sym_reg[STK_W-1:0];
                leaf_wd       = nu_reg;
                leaf_vld_next[sym_reg[STK_W-1:0]] = 1'b1;
                esc_next      = nu_inc;
                nu_next       = nu_reg + IDX_W'(2);
                u_next        = nu_reg;
                raw_cnt_next  = '0;
            end
            OP_U_LEAF:
            begin
                u_next = leaf_idx_reg;
            end
            OP_RD_U:
            begin
                rd_en   = 1'b1;
                rd_addr = u_reg;
            end
            OP_U_CAP:
            begin
                u_w_next      = rd_w;
                u_ord_next    = rd_ord;
                u_par_next    = rd_par_reg;
                lead_next     = u_reg;
                lead_ord_next = rd_ord;
                lead_par_next = rd_par_reg;
                i_next        = '0;
            end
            OP_RD_I:
            begin
                rd_en   = 1'b1;
                rd_addr = i_reg;
            end
            OP_CMP:
            begin
                if (rd_w == u_w_reg && rd_ord < lead_ord_reg)
                begin
                    lead_next     = rd_addr_reg;
                    lead_ord_next = rd_ord;
                    lead_par_next = rd_par_reg;
                end
                i_next = i_reg + IDX_W'(1);
            end
            OP_RD_PA:
            begin
                rd_en   = 1'b1;
                rd_addr = u_par_reg;
            end
            OP_CAP_A:
            begin
                a_right_next = (rd_right_reg == u_reg);
            end
            OP_RD_PB:
            begin
                rd_en   = 1'b1;
                rd_addr = lead_par_reg;
            end
            OP_CAP_B:
            begin
                b_right_next = (rd_right_reg == lead_reg);
            end
            OP_SW_A:
            begin
                right_we = a_right_reg;
                right_wa = u_par_reg;
                right_wd = lead_reg;
                par_we   = 1'b1;
                par_wa   = u_reg;
                par_wd   = lead_par_reg;
                ord_we   = 1'b1;
                ord_wa   = u_reg;
                ord_wd   = lead_ord_reg;
            end
            OP_SW_B:
            begin
                right_we   = b_right_reg;
                right_wa   = lead_par_reg;
                right_wd   = u_reg;
                par_we     = 1'b1;
                par_wa     = lead_reg;
                par_wd     = u_par_reg;
                ord_we     = 1'b1;
                ord_wa     = lead_reg;
                ord_wd     = u_ord_reg;
                u_par_next = lead_par_reg;
            end
            OP_INC:
            begin
                if (u_reg == '0)
                    root_w_next = u_w_reg + WEIGHT_BITS'(1);
                else
                begin
                    w_we = 1'b1;
                    w_wa = u_reg;
                    w_wd = u_w_reg + WEIGHT_BITS'(1);
                end
                u_next = u_par_reg;
            end
            OP_PAD:
            begin
                if (pend_fill_reg != '0)
                begin
                    push      = 1'b1;
                    push_byte = pend_bits_reg;
                end
                pend_bits_next = '0;
                pend_fill_next = '0;
            end
            OP_FINISH:
            begin
                if (hold_v_reg)
                begin
                    move      = 1'b1;
                    move_last = 1'b1;
                    move_byte = hold_byte_reg;
                    hold_v_next = 1'b0;
                end
                if (cmd_flag_reg == CMD_FLUSH)
                begin
                    nu_next        = IDX_W'(1);
                    esc_next       = '0;
                    any_seen_next  = 1'b0;
                    root_w_next    = '0;
                    leaf_vld_next  = '0;
                    pend_bits_next = '0;
                    pend_fill_next = '0;
                end
                else
                begin
                    any_seen_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (bit_put)
        begin
            bits_w = pend_bits_reg | (BYTE_W'(bit_val) << pend_fill_reg);
            if (pend_fill_reg == FILL_W'(BYTE_W - 1))
            begin
                push           = 1'b1;
                push_byte      = bits_w;
                pend_bits_next = '0;
                pend_fill_next = '0;
            end
            else
            begin
                pend_bits_next = bits_w;
                pend_fill_next = pend_fill_reg + FILL_W'(1);
            end
        end

        if (push)
        begin
            if (hold_v_reg)
            begin
                move      = 1'b1;
                move_last = 1'b0;
                move_byte = hold_byte_reg;
            end
            hold_byte_next = push_byte;
            hold_v_next    = 1'b1;
        end

        if (move)
        begin
            out_valid_next                = 1'b1;
            out_data_next.out_byte        = move_byte;
            out_data_next.last_of_run     = move_last;
            out_data_next.weight_overflow = ovf_reg;
        end
    end

    always_comb
    begin
        status.is_flush      = (cmd_flag_reg == CMD_FLUSH);
        status.sym_out_range = ({1'b0, sym_reg} >= (SYM_W + 1)'(ALPHABET));
        status.leaf_valid    = leaf_vld_reg[sym_reg[STK_W-1:0]];
        status.any_seen      = any_seen_reg;
        status.ovf           = ovf_reg;
        status.walk_more     = (x_reg != '0) && (depth_reg < DEPTH_W'(ALPHABET));
        status.depth_nz      = (depth_reg != '0);
        status.can_push      = !hold_v_reg || out_free;
        status.raw_last      = (raw_cnt_reg == 3'd7);
        status.scan_last     = (i_reg == nu_reg - IDX_W'(1));
        status.do_swap       = (u_reg != '0) && (lead_reg != u_reg) &&
                               (lead_reg != '0) && (lead_reg != u_par_reg);
        status.u_is_root     = (u_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
            par_mem[par_wa] <= par_wd;
        if (right_we)
            right_mem[right_wa] <= right_wd;
        if (w_we)
            w_mem[w_wa] <= w_wd;
        if (ord_we)
            ord_mem[ord_wa] <= ord_wd;
        if (rd_en)
        begin
            rd_addr_reg    <= rd_addr;
            rd_par_reg     <= par_mem[rd_addr];
            rd_right_reg   <= right_mem[rd_addr];
            rd_w_raw_reg   <= w_mem[rd_addr];
            rd_ord_raw_reg <= ord_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (leaf_we)
            leaf_mem[leaf_wa] <= leaf_wd;
        if (leaf_re)
            leaf_idx_reg <= leaf_mem[leaf_ra];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_wa] <= stk_wd;
        if (stk_re)
            stk_bit_reg <= stk_mem[stk_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nu_reg        <= IDX_W'(1);
            esc_reg       <= '0;
            any_seen_reg  <= 1'b0;
            pend_bits_reg <= '0;
            pend_fill_reg <= '0;
            root_w_reg    <= '0;
            leaf_vld_reg  <= '0;
            hold_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            nu_reg        <= nu_next;
            esc_reg       <= esc_next;
            any_seen_reg  <= any_seen_next;
            pend_bits_reg <= pend_bits_next;
            pend_fill_reg <= pend_fill_next;
            root_w_reg    <= root_w_next;
            leaf_vld_reg  <= leaf_vld_next;
            hold_v_reg    <= hold_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_flag_reg  <= cmd_flag_next;
        sym_reg       <= sym_next;
        ovf_reg       <= ovf_next;
        x_reg         <= x_next;
        p_reg         <= p_next;
        depth_reg     <= depth_next;
        raw_cnt_reg   <= raw_cnt_next;
        u_reg         <= u_next;
        u_w_reg       <= u_w_next;
        u_ord_reg     <= u_ord_next;
        u_par_reg     <= u_par_next;
        lead_reg      <= lead_next;
        lead_ord_reg  <= lead_ord_next;
        lead_par_reg  <= lead_par_next;
        i_reg         <= i_next;
        a_right_reg   <= a_right_next;
        b_right_reg   <= b_right_next;
        hold_byte_reg <= hold_byte_next;
        out_data_reg  <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `AHE_ASSERT_IMP(a_esc_live, clk, rst_n, 1'b1, esc_reg < nu_reg, "escape leaf not live")
    `AHE_ASSERT_IMP(a_nu_odd, clk, rst_n, 1'b1, nu_reg[0], "node count lost parity")
    `AHE_ASSERT_IMP(a_scan_bound, clk, rst_n, cmd.op == OP_CMP, i_reg < nu_reg, "scan past live nodes")
    `AHE_ASSERT_NXT(a_finish_drain, clk, rst_n, cmd.op == OP_FINISH, !hold_v_reg, "byte left held after item")

endmodule
